// ===== rtl/core/emg_envelope_level_meter_defines.svh =====
// Assertion macros shared by the envelope level meter RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef EMG_ENVELOPE_LEVEL_METER_DEFINES_SVH
`define EMG_ENVELOPE_LEVEL_METER_DEFINES_SVH

`ifndef SYNTHESIS
`define EMG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EMG_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EMG_ASSERT(lbl, prop, msg)
`define EMG_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/emg_pkg.sv =====
// Types, constants and helper functions for the envelope level meter.
// No dependencies; every module and interface of the block imports this package.
package emg_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int CENTER_BITS = SAMPLE_BITS + 1;
    localparam int ALPHA_BITS  = 16;
    localparam int FS_BITS     = 12;
    localparam int LEVEL_BITS  = 7;
    localparam int BLOCK_BITS  = 7;
    localparam int COUNT_BITS  = 6;
    localparam int LED_BITS    = 4;
    localparam int SERVO_BITS  = 8;
    localparam int PROD_BITS   = 15;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    localparam int MAX_BLOCK     = 64;
    localparam int PERCENT_SCALE = 100;
    localparam int SERVO_SPAN    = 180;
    localparam int SERVO_MID     = 90;
    localparam int QUEUE_DEPTH   = 2;

    // x / 100 == (x * DIV100_RECIP) >> DIV100_SHIFT for every x below 2**PROD_BITS
    localparam int DIV100_RECIP = 10486;
    localparam int DIV100_SHIFT = 20;
    localparam int DIV100_WIDE  = PROD_BITS + 14;

    localparam logic [SAMPLE_BITS-1:0] OFFSET_RST     = 12'd1280;
    localparam logic [ALPHA_BITS-1:0]  ALPHA_RST      = 16'd655;
    localparam logic [FS_BITS-1:0]     FULL_SCALE_RST = 12'd220;
    localparam logic [LEVEL_BITS-1:0]  DEAD_ZONE_RST  = 7'd35;
    localparam logic [BLOCK_BITS-1:0]  BLOCK_LEN_RST  = 7'd10;

    typedef enum logic [2:0] {
        REG_OFFSET,
        REG_ALPHA,
        REG_FULL_SCALE,
        REG_DEAD_ZONE,
        REG_BLOCK_LEN
    } emg_reg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] offset;
        logic [ALPHA_BITS-1:0]  alpha_q16;
        logic [FS_BITS-1:0]     full_scale;
        logic [LEVEL_BITS-1:0]  dead_zone;
        logic [BLOCK_BITS-1:0]  samples_per_update;
    } emg_cfg_t;

    typedef struct packed {
        logic [CENTER_BITS-1:0] centered;
        logic [SAMPLE_BITS-1:0] rect;
        logic                   block_end;
    } emg_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_ACC,
        ST_CLAMP,
        ST_DIV,
        ST_SCALE,
        ST_TRIM,
        ST_EMIT
    } emg_back_state_t;

    function automatic logic [SERVO_BITS-1:0] div100(input logic [PROD_BITS-1:0] x);
        logic [DIV100_WIDE-1:0] p;
        p = DIV100_WIDE'(x) * DIV100_WIDE'(DIV100_RECIP);
        return p[DIV100_SHIFT +: SERVO_BITS];
    endfunction

endpackage

// ===== rtl/core/emg_in_if.sv =====
// Sample channel: valid/ready handshake carrying one converter reading.
// Depends on emg_pkg for the sample width.
interface emg_in_if;
    import emg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink (input valid, input raw_sample, output ready);
endinterface

// ===== rtl/core/emg_out_if.sv =====
// Result channel: valid/ready handshake carrying the centered sample and levels.
// Depends on emg_pkg for the field widths.
interface emg_out_if;
    import emg_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [CENTER_BITS-1:0] centered_sample;
    logic                          level_update;
    logic [LEVEL_BITS-1:0]         level_percent;
    logic [LED_BITS-1:0]           leds_lit;
    logic signed [SERVO_BITS-1:0]  servo_angle;

    modport source (output valid, output centered_sample, output level_update,
                    output level_percent, output leds_lit, output servo_angle,
                    input ready);
    modport sink (input valid, input centered_sample, input level_update,
                  input level_percent, input leds_lit, input servo_angle,
                  output ready);
endinterface

// ===== rtl/core/emg_front.sv =====
// Front end: accepts samples, centers and rectifies them, marks block ends.
// Depends on emg_pkg and emg_in_if.
module emg_front (
    input  logic             clk,
    input  logic             rst_n,
    emg_in_if.sink           sample,
    input  emg_pkg::emg_cfg_t cfg,
    input  logic             full,
    output logic             push,
    output emg_pkg::emg_item_t item
);
    import emg_pkg::*;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [BLOCK_BITS-1:0] block_len;
    logic [BLOCK_BITS-1:0] count_plus;
    logic                  block_end;

    assign sample.ready = !full;
    assign push         = sample.valid && !full;

    always_comb
    begin
        if (cfg.samples_per_update == '0)
        begin
            block_len = BLOCK_BITS'(1);
        end
        else if (cfg.samples_per_update > BLOCK_BITS'(MAX_BLOCK))
        begin
            block_len = BLOCK_BITS'(MAX_BLOCK);
        end
        else
        begin
            block_len = cfg.samples_per_update;
        end

        count_plus = BLOCK_BITS'(count_reg) + BLOCK_BITS'(1);
        block_end  = count_plus >= block_len;

        item.centered  = {1'b0, sample.raw_sample} - {1'b0, cfg.offset};
        item.rect      = (sample.raw_sample >= cfg.offset) ? sample.raw_sample - cfg.offset
                                                           : cfg.offset - sample.raw_sample;
        item.block_end = block_end;

        count_next = count_reg;
        if (push)
        begin
            count_next = block_end ? '0 : count_plus[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/emg_queue.sv =====
// Short queue of classified samples between the front and back ends.
// Depends on emg_pkg and the assertion macros header.
`include "emg_envelope_level_meter_defines.svh"

module emg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  emg_pkg::emg_item_t wr_item,
    input  logic               pop,
    output emg_pkg::emg_item_t rd_item,
    output logic               full,
    output logic               empty
);
    import emg_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    emg_item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    assign full    = count_reg == CNT_BITS'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `EMG_ASSERT_NEVER(a_no_overflow, push && full, "queue written while full")
    `EMG_ASSERT_NEVER(a_no_underflow, pop && empty, "queue read while empty")
    `EMG_ASSERT(a_count_range, count_reg <= CNT_BITS'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== rtl/core/emg_back.sv =====
// Back end: envelope update, block-end clamp, serial percent divide, level scaling
// and the output register. Depends on emg_pkg, emg_out_if and the macros header.
`include "emg_envelope_level_meter_defines.svh"

module emg_back #(
    parameter int FRAC_BITS = 16,
    parameter int LED_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  emg_pkg::emg_cfg_t  cfg,
    input  logic               empty,
    input  emg_pkg::emg_item_t rd_item,
    output logic               pop,
    emg_out_if.source          result
);
    import emg_pkg::*;

    localparam int EW = SAMPLE_BITS + FRAC_BITS;      // envelope width
    localparam int PW = EW + ALPHA_BITS + 2;          // weighted difference width
    localparam int NW = EW + LEVEL_BITS;              // dividend width
    localparam int BC = $clog2(LEVEL_BITS);

    emg_back_state_t        state_reg, state_next;
    emg_item_t              item_reg, item_next;
    logic [EW-1:0]          env_reg, env_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic [NW-1:0]          rem_reg, rem_next;
    logic [NW-1:0]          dvs_reg, dvs_next;
    logic [LEVEL_BITS-1:0]  quo_reg, quo_next;
    logic [BC-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [LEVEL_BITS-1:0]  held_reg, held_next;
    logic [PROD_BITS-1:0]   led_prod_reg, led_prod_next;
    logic [PROD_BITS-1:0]   servo_prod_reg, servo_prod_next;
    logic [LED_BITS-1:0]    leds_reg, leds_next;
    logic [SERVO_BITS-1:0]  servo_reg, servo_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CENTER_BITS-1:0] out_centered_reg, out_centered_next;
    logic                   out_update_reg, out_update_next;
    logic [LEVEL_BITS-1:0]  out_level_reg, out_level_next;
    logic [LED_BITS-1:0]    out_leds_reg, out_leds_next;
    logic [SERVO_BITS-1:0]  out_servo_reg, out_servo_next;

    logic [FS_BITS-1:0]     fs;
    logic [EW-1:0]          full_q;
    logic [EW-1:0]          rect_q;
    logic [EW-1:0]          env_c;
    logic signed [EW:0]     diff;
    logic signed [PW-1:0]   acc;
    logic [LEVEL_BITS-1:0]  level;
    logic [SERVO_BITS-1:0]  led_q;
    logic [SERVO_BITS-1:0]  servo_q;

    assign result.valid           = out_valid_reg;
    assign result.centered_sample = $signed(out_centered_reg);
    assign result.level_update    = out_update_reg;
    assign result.level_percent   = out_level_reg;
    assign result.leds_lit        = out_leds_reg;
    assign result.servo_angle     = $signed(out_servo_reg);

    always_comb
    begin
        fs     = (cfg.full_scale == '0) ? FS_BITS'(1) : cfg.full_scale;
        full_q = {fs, {FRAC_BITS{1'b0}}};
        rect_q = {item_reg.rect, {FRAC_BITS{1'b0}}};
        env_c  = (env_reg > full_q) ? full_q : env_reg;
        // env + alpha*(rect - env) / 2^16, floored; equals the weighted average.
        diff   = $signed({1'b0, rect_q}) - $signed({1'b0, env_reg});
        acc    = $signed({{(PW - EW){1'b0}}, env_reg}) + (prod_reg >>> ALPHA_BITS);
        level  = (quo_reg < cfg.dead_zone) ? '0 : quo_reg;
        led_q  = div100(led_prod_reg);
        servo_q = div100(servo_prod_reg);

        state_next      = state_reg;
        item_next       = item_reg;
        env_next        = env_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        quo_next        = quo_reg;
        bit_cnt_next    = bit_cnt_reg;
        held_next       = held_reg;
        led_prod_next   = led_prod_reg;
        servo_prod_next = servo_prod_reg;
        leds_next       = leds_reg;
        servo_next      = servo_reg;
        pop             = 1'b0;

        out_valid_next    = out_valid_reg && !result.ready;
        out_centered_next = out_centered_reg;
        out_update_next   = out_update_reg;
        out_level_next    = out_level_reg;
        out_leds_next     = out_leds_reg;
        out_servo_next    = out_servo_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    item_next  = rd_item;
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                prod_next  = $signed({1'b0, cfg.alpha_q16}) * diff;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                env_next   = acc[EW-1:0];
                state_next = item_reg.block_end ? ST_CLAMP : ST_EMIT;
            end
            ST_CLAMP:
            begin
                env_next     = env_c;
                rem_next     = NW'(env_c) * NW'(PERCENT_SCALE);
                dvs_next     = NW'({full_q, {(LEVEL_BITS - 1){1'b0}}});
                quo_next     = '0;
                bit_cnt_next = BC'(LEVEL_BITS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // Restoring divide, one quotient bit per cycle, MSB first.
                if (rem_reg >= dvs_reg)
                begin
                    rem_next = rem_reg - dvs_reg;
                    quo_next = {quo_reg[LEVEL_BITS-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[LEVEL_BITS-2:0], 1'b0};
                end
                dvs_next = dvs_reg >> 1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SCALE:
            begin
                held_next       = level;
                led_prod_next   = PROD_BITS'(level) * PROD_BITS'(LED_COUNT);
                servo_prod_next = PROD_BITS'(level) * PROD_BITS'(SERVO_SPAN);
                state_next      = ST_TRIM;
            end
            ST_TRIM:
            begin
                leds_next  = led_q[LED_BITS-1:0];
                servo_next = SERVO_BITS'(SERVO_MID) - servo_q;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_centered_next = item_reg.centered;
                    out_update_next   = item_reg.block_end;
                    out_level_next    = held_reg;
                    out_leds_next     = leds_reg;
                    out_servo_next    = servo_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            env_reg       <= '0;
            held_reg      <= '0;
            leds_reg      <= '0;
            servo_reg     <= SERVO_BITS'(SERVO_MID);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            env_reg       <= env_next;
            held_reg      <= held_next;
            leds_reg      <= leds_next;
            servo_reg     <= servo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        prod_reg         <= prod_next;
        rem_reg          <= rem_next;
        dvs_reg          <= dvs_next;
        quo_reg          <= quo_next;
        bit_cnt_reg      <= bit_cnt_next;
        led_prod_reg     <= led_prod_next;
        servo_prod_reg   <= servo_prod_next;
        out_centered_reg <= out_centered_next;
        out_update_reg   <= out_update_next;
        out_level_reg    <= out_level_next;
        out_leds_reg     <= out_leds_next;
        out_servo_reg    <= out_servo_next;
    end

    `EMG_ASSERT(a_quo_range, (state_reg == ST_SCALE) |-> (quo_reg <= LEVEL_BITS'(PERCENT_SCALE)), "percent above one hundred")
    `EMG_ASSERT(a_env_clamped, (state_reg == ST_DIV) |-> (env_reg <= full_q), "envelope not clamped during divide")
    `EMG_ASSERT(a_emit_source, $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT), "result raised outside emit")

endmodule

// ===== rtl/core/emg_envelope_level_meter.sv =====
// The back-end sequencer takes a sample word through the states idle, multiply,
// accumulate and emit; a word that closes a block also passes clamp, the bit-serial
// percent divide, scale and trim. It takes no new word from the queue until the last
// one is emitted, and emit waits while the result channel applies back-pressure.
// Reset (rst_n, asynchronous, active low) loads the register defaults and clears the
// envelope, block count, held level and queue; no clearing pass is needed.
module emg_envelope_level_meter #(
    parameter int FRAC_BITS = 16,
    parameter int LED_COUNT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    emg_in_if.sink                           sample,
    emg_out_if.source                        result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [emg_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [emg_pkg::DATA_BITS-1:0]    pwdata,
    output logic [emg_pkg::DATA_BITS-1:0]    prdata,
    output logic                             pready
);
    import emg_pkg::*;

    logic [SAMPLE_BITS-1:0] offset_reg;
    logic [ALPHA_BITS-1:0]  alpha_reg;
    logic [FS_BITS-1:0]     full_scale_reg;
    logic [LEVEL_BITS-1:0]  dead_zone_reg;
    logic [BLOCK_BITS-1:0]  block_len_reg;

    emg_cfg_t  cfg;
    emg_item_t wr_item;
    emg_item_t rd_item;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    assign cfg.offset             = offset_reg;
    assign cfg.alpha_q16          = alpha_reg;
    assign cfg.full_scale         = full_scale_reg;
    assign cfg.dead_zone          = dead_zone_reg;
    assign cfg.samples_per_update = block_len_reg;

    always_comb
    begin
        case (paddr[ADDR_BITS-1:2])
            REG_OFFSET:     prdata = DATA_BITS'(offset_reg);
            REG_ALPHA:      prdata = DATA_BITS'(alpha_reg);
            REG_FULL_SCALE: prdata = DATA_BITS'(full_scale_reg);
            REG_DEAD_ZONE:  prdata = DATA_BITS'(dead_zone_reg);
            REG_BLOCK_LEN:  prdata = DATA_BITS'(block_len_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= OFFSET_RST;
            alpha_reg      <= ALPHA_RST;
            full_scale_reg <= FULL_SCALE_RST;
            dead_zone_reg  <= DEAD_ZONE_RST;
            block_len_reg  <= BLOCK_LEN_RST;
        end
        else if (wr_en)
        begin
            case (paddr[ADDR_BITS-1:2])
                REG_OFFSET:     offset_reg     <= pwdata[SAMPLE_BITS-1:0];
                REG_ALPHA:      alpha_reg      <= pwdata[ALPHA_BITS-1:0];
                REG_FULL_SCALE: full_scale_reg <= pwdata[FS_BITS-1:0];
                REG_DEAD_ZONE:  dead_zone_reg  <= pwdata[LEVEL_BITS-1:0];
                REG_BLOCK_LEN:  block_len_reg  <= pwdata[BLOCK_BITS-1:0];
                default:        ;
            endcase
        end
    end

    emg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cfg    (cfg),
        .full   (full),
        .push   (push),
        .item   (wr_item)
    );

    emg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .full    (full),
        .empty   (empty)
    );

    emg_back #(
        .FRAC_BITS (FRAC_BITS),
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .empty   (empty),
        .rd_item (rd_item),
        .pop     (pop),
        .result  (result)
    );

endmodule
